>>> rtl/xsf_pkg.sv
// ----------------------------------------------------------------------------
// xsf_pkg
// Shared types, constants and wrap tables for the xor sprite framebuffer.
// ----------------------------------------------------------------------------
`default_nettype none

package xsf_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int ROW_BITS      = 64;
  localparam int SPRITE_BITS   = 8;

  localparam int COL_W = $clog2(SCREEN_WIDTH);
  localparam int ROW_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [3:0] row_index;
    logic [7:0] row_bits;
    logic       last_row;
  } cmd_t;

  typedef struct packed {
    logic                collision;
    logic                sprite_done;
    logic [ROW_BITS-1:0] pixel_row;
  } rsp_t;

  typedef struct packed {
    logic                clr;
    logic                we;
    logic [ROW_W-1:0]    addr;
    logic [ROW_BITS-1:0] data;
  } frame_ctl_t;

  // constant lookup: v mod SCREEN_WIDTH
  function automatic logic [COL_W-1:0] wrap_col(input logic [7:0] v);
    logic [COL_W-1:0] r;
    r = '0;
    for (int k = 0; k < 256; k++) begin
      if (v == 8'(k)) r = COL_W'(k % SCREEN_WIDTH);
    end
    return r;
  endfunction

  // constant lookup: v mod SCREEN_HEIGHT
  function automatic logic [ROW_W-1:0] wrap_row(input logic [7:0] v);
    logic [ROW_W-1:0] r;
    r = '0;
    for (int k = 0; k < 256; k++) begin
      if (v == 8'(k)) r = ROW_W'(k % SCREEN_HEIGHT);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/xsf_draw_addr.sv
// ----------------------------------------------------------------------------
// xsf_draw_addr
// Wrapped row addresses and the 64-bit xor mask of one sprite row.
// ----------------------------------------------------------------------------
`default_nettype none

module xsf_draw_addr
  import xsf_pkg::*;
(
  input  wire cmd_t                cmd,
  output logic [ROW_W-1:0]    draw_row,
  output logic [ROW_W-1:0]    read_row,
  output logic [ROW_BITS-1:0] mask
);

  logic [COL_W-1:0] x0;
  logic [ROW_W-1:0] y0;
  logic [ROW_W-1:0] ri_mod;
  logic [ROW_W:0]   row_sum;

  always_comb begin
    x0       = wrap_col(cmd.x_pos);
    y0       = wrap_row(cmd.y_pos);
    ri_mod   = wrap_row({4'd0, cmd.row_index});
    read_row = y0;
    row_sum  = {1'b0, y0} + {1'b0, ri_mod};
    if (row_sum >= (ROW_W+1)'(SCREEN_HEIGHT)) begin
      row_sum = row_sum - (ROW_W+1)'(SCREEN_HEIGHT);
    end
    draw_row = row_sum[ROW_W-1:0];
  end

  // one column per sprite pixel, each wrapped on its own
  always_comb begin
    logic [COL_W:0] col;
    mask = '0;
    for (int j = 0; j < SPRITE_BITS; j++) begin
      col = {1'b0, x0} + (COL_W+1)'(j);
      if (col >= (COL_W+1)'(SCREEN_WIDTH)) begin
        col = col - (COL_W+1)'(SCREEN_WIDTH);
      end
      if (cmd.row_bits[SPRITE_BITS-1-j]) begin
        mask[6'(ROW_BITS-1) - 6'(col)] = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/xsf_frame_store.sv
// ----------------------------------------------------------------------------
// xsf_frame_store
// Framebuffer rows with per-row valid bits, so a clear only resets the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module xsf_frame_store
  import xsf_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst,
  input  wire frame_ctl_t          ctl,
  input  wire [ROW_W-1:0]          rd_addr,
  output logic [ROW_BITS-1:0]      rd_data
);

  logic [ROW_BITS-1:0]      rows [SCREEN_HEIGHT];
  logic [SCREEN_HEIGHT-1:0] row_valid;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      rows[ctl.addr] <= ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      row_valid <= '0;
    end else if (ctl.we) begin
      row_valid[ctl.addr] <= 1'b1;
    end
  end

  assign rd_data = row_valid[rd_addr] ? rows[rd_addr] : '0;

`ifndef SYNTHESIS
  a_clear_empties : assert property (@(posedge clk) disable iff (rst)
    ctl.clr |=> row_valid == '0)
    else $error("clear left a row valid");

  a_write_marks : assert property (@(posedge clk) disable iff (rst)
    ctl.we |=> row_valid[$past(ctl.addr)])
    else $error("written row not marked valid");

  a_clr_excl_we : assert property (@(posedge clk) disable iff (rst)
    ctl.clr |-> !ctl.we)
    else $error("clear and write in the same cycle");
`endif

endmodule

`default_nettype wire

>>> rtl/xor_sprite_framebuffer_unit.sv
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer_unit
// 64x32 one-bit framebuffer with clear, xor sprite-row draw and row read.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one command beat: clear,
//   draw one 8-pixel sprite row with wrap, or read one framebuffer row.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one beat per
//   command, in order: collision and sprite_done for draws, pixel_row
//   for reads, all zero otherwise.
//   Commands pass the command register, then the response register (rsp_valid).
//   Throughput is one command per cycle while rsp_ready is high; each draw is one
//   read-modify-write of a single row register, done between the two registers.
//   Reset (rst, synchronous) empties both stages, zeroes the collision flag
//   and marks every row invalid, so the screen reads as all zero.
//   When rsp_ready is low, the response register holds its beat and the
//   command register holds one more beat; cmd_ready drops once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_sprite_framebuffer_unit
  import xsf_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        cmd_valid,
  output logic       cmd_ready,
  input  wire cmd_t  cmd,
  output logic       rsp_valid,
  input  wire        rsp_ready,
  output rsp_t       rsp
);

  logic                s1_valid;
  cmd_t                s1;
  logic                advance;
  logic                coll_acc;
  logic                coll_acc_next;
  logic [ROW_W-1:0]    draw_row;
  logic [ROW_W-1:0]    read_row;
  logic [ROW_BITS-1:0] mask;
  logic [ROW_BITS-1:0] rd_data;
  logic [ROW_W-1:0]    rd_addr;
  frame_ctl_t          ctl;
  rsp_t                rsp_next;

  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign cmd_ready = !s1_valid || advance;

  xsf_draw_addr u_addr (
    .cmd      (s1),
    .draw_row (draw_row),
    .read_row (read_row),
    .mask     (mask)
  );

  xsf_frame_store u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    rd_addr       = (s1.opcode == OP_READ) ? read_row : draw_row;
    coll_acc_next = ((s1.row_index == 4'd0) ? 1'b0 : coll_acc) | (|(rd_data & mask));
    ctl.clr       = advance && (s1.opcode == OP_CLEAR);
    ctl.we        = advance && (s1.opcode == OP_DRAW);
    ctl.addr      = draw_row;
    ctl.data      = rd_data ^ mask;
    rsp_next      = '0;
    case (s1.opcode)
      OP_DRAW: begin
        rsp_next.collision   = coll_acc_next;
        rsp_next.sprite_done = s1.last_row;
      end
      OP_READ: begin
        rsp_next.pixel_row = rd_data;
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      coll_acc  <= 1'b0;
    end else begin
      if (cmd_ready) begin
        s1_valid <= cmd_valid;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (ctl.we) begin
        coll_acc <= coll_acc_next;
      end
    end
    if (cmd_valid && cmd_ready) begin
      s1 <= cmd;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_empty_takes : assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> cmd_ready)
    else $error("empty command stage refused a beat");

  a_stage_holds : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1)))
    else $error("stalled command stage lost its beat");

  a_read_fields : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.pixel_row != '0)) |-> (!rsp.collision && !rsp.sprite_done))
    else $error("read beat carries draw status");
`endif

endmodule

`default_nettype wire
